@@ src/fslu_pkg.sv @@
// ----------------------------------------------------------------------------
// fslu_pkg
// Shared types and constants of the feature statistics lifecycle unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fslu_pkg;

  localparam int unsigned CntW     = 32;
  localparam int unsigned DeltaW   = 40;
  localparam int unsigned DaysW    = 16;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned DecayW   = 17;
  localparam int unsigned CmdW     = 3;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ProdW    = CntW + DecayW;
  localparam int unsigned Latency  = 5;

  localparam logic [CmdW-1:0] CMD_UPDATE     = 3'd0;
  localparam logic [CmdW-1:0] CMD_SHRINK     = 3'd1;
  localparam logic [CmdW-1:0] CMD_SAVE_CHECK = 3'd2;
  localparam logic [CmdW-1:0] CMD_CACHE_CHK  = 3'd3;
  localparam logic [CmdW-1:0] CMD_AFTER_SAVE = 3'd4;

  localparam logic [ModeW-1:0] MODE_DELTA       = 3'd1;
  localparam logic [ModeW-1:0] MODE_DELTA_CLEAR = 3'd2;
  localparam logic [ModeW-1:0] MODE_AGE         = 3'd3;

  localparam logic [CfgIdxW-1:0] REG_NONCLICK_COEFF    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CLICK_WEIGHT      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DECAY_RATE        = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DROP_FLOOR        = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DELETE_AFTER_DAYS = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SAVE_FLOOR        = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DELTA_FLOOR       = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_KEEP_DAYS         = 3'd7;

  localparam logic signed [DeltaW-1:0] DELTA_MAX = {1'b0, {(DeltaW-1){1'b1}}};
  localparam logic signed [DeltaW-1:0] DELTA_MIN = {1'b1, {(DeltaW-1){1'b0}}};
  localparam logic [DaysW-1:0]         DAYS_MAX  = '1;
  localparam logic [CntW-1:0]          CNT_MAX   = '1;

  typedef struct packed {
    logic [CoefW-1:0]  nonclick_coeff;
    logic [CoefW-1:0]  click_weight;
    logic [DecayW-1:0] decay_rate;
    logic [CntW-1:0]   drop_floor;
    logic [DaysW-1:0]  delete_after_days;
    logic [CntW-1:0]   save_floor;
    logic [CntW-1:0]   delta_floor;
    logic [DaysW-1:0]  keep_days;
  } cfg_t;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic [ModeW-1:0]         mode;
    logic [CntW-1:0]          show;
    logic [CntW-1:0]          click;
    logic signed [DeltaW-1:0] delta;
    logic [DaysW-1:0]         unseen;
    logic [CntW-1:0]          slot;
    logic                     last;
    logic                     cache_hit;
  } side_t;

endpackage

`default_nettype wire

@@ src/fslu_decay.sv @@
// ----------------------------------------------------------------------------
// fslu_decay
// Stages 1-2: update sums, decay products and selection of score operands.
// ----------------------------------------------------------------------------
`default_nettype none

module fslu_decay (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fslu_pkg::cfg_t                  cfg_i,
  input  wire logic                            valid_i,
  input  wire logic [fslu_pkg::CmdW-1:0]       command_i,
  input  wire logic [fslu_pkg::ModeW-1:0]      save_mode_i,
  input  wire logic [fslu_pkg::CntW-1:0]       show_i,
  input  wire logic [fslu_pkg::CntW-1:0]       click_i,
  input  wire logic signed [fslu_pkg::DeltaW-1:0] delta_score_i,
  input  wire logic [fslu_pkg::DaysW-1:0]      unseen_days_i,
  input  wire logic [fslu_pkg::CntW-1:0]       slot_i,
  input  wire logic [fslu_pkg::CntW-1:0]       show_inc_i,
  input  wire logic [fslu_pkg::CntW-1:0]       click_inc_i,
  input  wire logic [fslu_pkg::CntW-1:0]       push_slot_i,
  input  wire logic [fslu_pkg::CntW-1:0]       cache_threshold_i,
  input  wire logic                            batch_last_i,
  output logic                                 valid_o,
  output fslu_pkg::side_t                      side_o,
  output logic [fslu_pkg::CntW-1:0]            op_a_o,
  output logic [fslu_pkg::CntW-1:0]            op_b_o
);

  localparam int unsigned CntW  = fslu_pkg::CntW;
  localparam int unsigned ProdW = fslu_pkg::ProdW;

  logic                 is_upd;
  logic [CntW:0]        sum_show, sum_click;
  fslu_pkg::side_t      side1_d, side1_q;
  logic [CntW-1:0]      op_a1_d, op_a1_q, op_b1_d, op_b1_q;
  logic [ProdW-1:0]     prod_show_d, prod_show_q, prod_click_d, prod_click_q;
  logic                 valid1_q, valid2_q;
  logic [CntW-1:0]      dec_show, dec_click;
  fslu_pkg::side_t      side2_d, side2_q;
  logic [CntW-1:0]      op_a2_d, op_a2_q, op_b2_d, op_b2_q;

  // stage 1
  always_comb begin
    is_upd    = (command_i == fslu_pkg::CMD_UPDATE);
    sum_show  = {1'b0, show_i} + {1'b0, show_inc_i};
    sum_click = {1'b0, click_i} + {1'b0, click_inc_i};

    side1_d.cmd       = command_i;
    side1_d.mode      = save_mode_i;
    side1_d.delta     = delta_score_i;
    side1_d.unseen    = unseen_days_i;
    side1_d.last      = batch_last_i;
    side1_d.cache_hit = (show_i > cache_threshold_i);
    if (is_upd) begin
      side1_d.show  = sum_show[CntW]  ? fslu_pkg::CNT_MAX : sum_show[CntW-1:0];
      side1_d.click = sum_click[CntW] ? fslu_pkg::CNT_MAX : sum_click[CntW-1:0];
      side1_d.slot  = push_slot_i;
      op_a1_d       = show_inc_i;
      op_b1_d       = click_inc_i;
    end else begin
      side1_d.show  = show_i;
      side1_d.click = click_i;
      side1_d.slot  = slot_i;
      op_a1_d       = show_i;
      op_b1_d       = click_i;
    end
    prod_show_d  = ProdW'(show_i)  * ProdW'(cfg_i.decay_rate);
    prod_click_d = ProdW'(click_i) * ProdW'(cfg_i.decay_rate);
  end

  // stage 2: shift by 16, saturate to 32 bits
  always_comb begin
    dec_show  = prod_show_q[ProdW-1]  ? fslu_pkg::CNT_MAX : prod_show_q[ProdW-2:16];
    dec_click = prod_click_q[ProdW-1] ? fslu_pkg::CNT_MAX : prod_click_q[ProdW-2:16];
    side2_d   = side1_q;
    op_a2_d   = op_a1_q;
    op_b2_d   = op_b1_q;
    if (side1_q.cmd == fslu_pkg::CMD_SHRINK) begin
      side2_d.show  = dec_show;
      side2_d.click = dec_click;
      op_a2_d       = dec_show;
      op_b2_d       = dec_click;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side1_q      <= side1_d;
    op_a1_q      <= op_a1_d;
    op_b1_q      <= op_b1_d;
    prod_show_q  <= prod_show_d;
    prod_click_q <= prod_click_d;
    side2_q      <= side2_d;
    op_a2_q      <= op_a2_d;
    op_b2_q      <= op_b2_d;
  end

  assign valid_o = valid2_q;
  assign side_o  = side2_q;
  assign op_a_o  = op_a2_q;
  assign op_b_o  = op_b2_q;

endmodule

`default_nettype wire

@@ src/fslu_score.sv @@
// ----------------------------------------------------------------------------
// fslu_score
// Stages 3-4: weighted score products, floor shift by 8, saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module fslu_score (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fslu_pkg::cfg_t                  cfg_i,
  input  wire logic                            valid_i,
  input  wire fslu_pkg::side_t                 side_i,
  input  wire logic [fslu_pkg::CntW-1:0]       op_a_i,
  input  wire logic [fslu_pkg::CntW-1:0]       op_b_i,
  output logic                                 valid_o,
  output fslu_pkg::side_t                      side_o,
  output logic signed [fslu_pkg::DeltaW-1:0]   score_o
);

  localparam int unsigned CntW   = fslu_pkg::CntW;
  localparam int unsigned CoefW  = fslu_pkg::CoefW;
  localparam int unsigned DeltaW = fslu_pkg::DeltaW;
  localparam int unsigned NcW    = CntW + 1 + CoefW + 1;
  localparam int unsigned CcW    = CntW + CoefW;
  localparam int unsigned SumW   = NcW + 1;
  localparam int unsigned ShW    = SumW - 8;

  logic signed [CntW:0]     diff;
  logic signed [NcW-1:0]    prod_nc_d, prod_nc_q;
  logic [CcW-1:0]           prod_cc_d, prod_cc_q;
  fslu_pkg::side_t          side3_q, side4_q;
  logic                     valid3_q, valid4_q;
  logic signed [SumW-1:0]   sum;
  logic signed [ShW-1:0]    shifted;
  logic signed [DeltaW-1:0] score_d, score_q;

  always_comb begin
    diff      = $signed({1'b0, op_a_i}) - $signed({1'b0, op_b_i});
    prod_nc_d = NcW'(diff) * NcW'($signed({1'b0, cfg_i.nonclick_coeff}));
    prod_cc_d = CcW'(op_b_i) * CcW'(cfg_i.click_weight);
  end

  always_comb begin
    sum     = $signed({prod_nc_q[NcW-1], prod_nc_q}) + $signed({{(SumW-CcW){1'b0}}, prod_cc_q});
    shifted = sum[SumW-1:8];
    if (shifted[ShW-1:DeltaW-1] == '0 || shifted[ShW-1:DeltaW-1] == '1) begin
      score_d = shifted[DeltaW-1:0];
    end else if (shifted[ShW-1]) begin
      score_d = fslu_pkg::DELTA_MIN;
    end else begin
      score_d = fslu_pkg::DELTA_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_nc_q <= prod_nc_d;
    prod_cc_q <= prod_cc_d;
    side3_q   <= side_i;
    side4_q   <= side3_q;
    score_q   <= score_d;
  end

  assign valid_o = valid4_q;
  assign side_o  = side4_q;
  assign score_o = score_q;

endmodule

`default_nettype wire

@@ src/fslu_decide.sv @@
// ----------------------------------------------------------------------------
// fslu_decide
// Stage 5: threshold compares, delta update and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fslu_decide (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire fslu_pkg::cfg_t                  cfg_i,
  input  wire logic                            valid_i,
  input  wire fslu_pkg::side_t                 side_i,
  input  wire logic signed [fslu_pkg::DeltaW-1:0] score_i,
  output logic                                 done_o,
  output logic [fslu_pkg::CntW-1:0]            new_show_o,
  output logic [fslu_pkg::CntW-1:0]            new_click_o,
  output logic signed [fslu_pkg::DeltaW-1:0]   new_delta_score_o,
  output logic [fslu_pkg::DaysW-1:0]           new_unseen_days_o,
  output logic [fslu_pkg::CntW-1:0]            new_slot_o,
  output logic                                 decision_o,
  output logic                                 result_last_o
);

  localparam int unsigned CntW   = fslu_pkg::CntW;
  localparam int unsigned DeltaW = fslu_pkg::DeltaW;
  localparam int unsigned DaysW  = fslu_pkg::DaysW;
  localparam int unsigned PadW   = DeltaW + 1 - CntW;

  logic signed [DeltaW:0]   score_x, delta_x, dsum;
  logic [CntW-1:0]          dthr;
  logic                     ge_base, ge_delta, le_keep, ok;
  logic signed [DeltaW-1:0] delta_d, delta_q, dsum_sat;
  logic [DaysW-1:0]         unseen_d, unseen_q;
  logic [CntW-1:0]          slot_d, slot_q, show_q, click_q;
  logic                     dec_d, dec_q, done_q, last_q;

  always_comb begin
    score_x  = {score_i[DeltaW-1], score_i};
    delta_x  = {side_i.delta[DeltaW-1], side_i.delta};
    dthr     = (side_i.mode == fslu_pkg::MODE_DELTA_CLEAR) ? '0 : cfg_i.delta_floor;
    ge_base  = score_x >= $signed({{PadW{1'b0}}, cfg_i.save_floor});
    ge_delta = delta_x >= $signed({{PadW{1'b0}}, dthr});
    le_keep  = side_i.unseen <= cfg_i.keep_days;
    ok       = ge_base && ge_delta && le_keep;
    dsum     = delta_x + score_x;
    if (dsum[DeltaW] == dsum[DeltaW-1]) begin
      dsum_sat = dsum[DeltaW-1:0];
    end else if (dsum[DeltaW]) begin
      dsum_sat = fslu_pkg::DELTA_MIN;
    end else begin
      dsum_sat = fslu_pkg::DELTA_MAX;
    end

    delta_d  = side_i.delta;
    unseen_d = side_i.unseen;
    slot_d   = side_i.slot;
    dec_d    = 1'b0;
    unique case (side_i.cmd)
      fslu_pkg::CMD_UPDATE: begin
        delta_d  = dsum_sat;
        unseen_d = '0;
      end
      fslu_pkg::CMD_SHRINK: begin
        dec_d = (score_x < $signed({{PadW{1'b0}}, cfg_i.drop_floor})) ||
                (side_i.unseen > cfg_i.delete_after_days);
      end
      fslu_pkg::CMD_SAVE_CHECK: begin
        if (side_i.mode inside {fslu_pkg::MODE_DELTA, fslu_pkg::MODE_DELTA_CLEAR}) begin
          dec_d = ok;
          if (ok && side_i.mode == fslu_pkg::MODE_DELTA_CLEAR) begin
            delta_d = '0;
          end
        end else begin
          dec_d = 1'b1;
        end
      end
      fslu_pkg::CMD_CACHE_CHK: begin
        dec_d = ge_base && le_keep && side_i.cache_hit;
      end
      fslu_pkg::CMD_AFTER_SAVE: begin
        if (side_i.mode == fslu_pkg::MODE_DELTA) begin
          if (ok) begin
            delta_d = '0;
          end
        end else if (side_i.mode == fslu_pkg::MODE_AGE) begin
          if (side_i.unseen != fslu_pkg::DAYS_MAX) begin
            unseen_d = side_i.unseen + DaysW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    show_q   <= side_i.show;
    click_q  <= side_i.click;
    delta_q  <= delta_d;
    unseen_q <= unseen_d;
    slot_q   <= slot_d;
    dec_q    <= dec_d;
    last_q   <= side_i.last;
  end

  assign done_o            = done_q;
  assign new_show_o        = show_q;
  assign new_click_o       = click_q;
  assign new_delta_score_o = delta_q;
  assign new_unseen_days_o = unseen_q;
  assign new_slot_o        = slot_q;
  assign decision_o        = dec_q;
  assign result_last_o     = last_q;

endmodule

`default_nettype wire

@@ src/feature_stat_lifecycle_unit.sv @@
// ----------------------------------------------------------------------------
// feature_stat_lifecycle_unit
// Show/click/score bookkeeping for one embedding-table entry per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the entry fields with start_i high; the item is
//   taken at that edge when busy_o is low. busy_o never rises, so a new
//   item may be issued in every cycle.
//   Result channel: done_o is high for one cycle with the updated entry,
//   decision_o and result_last_o. The receiver cannot stall; results
//   leave in issue order.
//   Throughput is one item per cycle. Stages: update sums and decay
//   multiplies, decay saturation, score multiplies, score sum/shift,
//   compares and result register.
//   Configuration: cfg_we_i, cfg_idx_i and cfg_wdata_i write one register
//   per edge; write only while no item is in flight.
//   Reset: clears all pipeline valid bits and loads the register defaults;
//   the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module feature_stat_lifecycle_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [fslu_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [fslu_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic [fslu_pkg::CmdW-1:0]           command_i,
  input  wire logic [fslu_pkg::ModeW-1:0]          save_mode_i,
  input  wire logic [fslu_pkg::CntW-1:0]           show_i,
  input  wire logic [fslu_pkg::CntW-1:0]           click_i,
  input  wire logic signed [fslu_pkg::DeltaW-1:0]  delta_score_i,
  input  wire logic [fslu_pkg::DaysW-1:0]          unseen_days_i,
  input  wire logic signed [fslu_pkg::CntW-1:0]    slot_i,
  input  wire logic [fslu_pkg::CntW-1:0]           show_inc_i,
  input  wire logic [fslu_pkg::CntW-1:0]           click_inc_i,
  input  wire logic signed [fslu_pkg::CntW-1:0]    push_slot_i,
  input  wire logic [fslu_pkg::CntW-1:0]           cache_threshold_i,
  input  wire logic                                batch_last_i,
  output logic                                     done_o,
  output logic [fslu_pkg::CntW-1:0]                new_show_o,
  output logic [fslu_pkg::CntW-1:0]                new_click_o,
  output logic signed [fslu_pkg::DeltaW-1:0]       new_delta_score_o,
  output logic [fslu_pkg::DaysW-1:0]               new_unseen_days_o,
  output logic signed [fslu_pkg::CntW-1:0]         new_slot_o,
  output logic                                     decision_o,
  output logic                                     result_last_o
);

  fslu_pkg::cfg_t                    cfg_q;
  logic                              accept;
  logic                              v2, v4;
  fslu_pkg::side_t                   side2, side4;
  logic [fslu_pkg::CntW-1:0]         op_a, op_b;
  logic signed [fslu_pkg::DeltaW-1:0] score;
  logic [fslu_pkg::CntW-1:0]         slot_out;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nonclick_coeff    <= 16'd26;
      cfg_q.click_weight      <= 16'd256;
      cfg_q.decay_rate        <= 17'd65536;
      cfg_q.drop_floor        <= '0;
      cfg_q.delete_after_days <= 16'd30;
      cfg_q.save_floor        <= '0;
      cfg_q.delta_floor       <= '0;
      cfg_q.keep_days         <= 16'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fslu_pkg::REG_NONCLICK_COEFF:    cfg_q.nonclick_coeff    <= cfg_wdata_i[15:0];
        fslu_pkg::REG_CLICK_WEIGHT:      cfg_q.click_weight      <= cfg_wdata_i[15:0];
        fslu_pkg::REG_DECAY_RATE:        cfg_q.decay_rate        <= cfg_wdata_i[16:0];
        fslu_pkg::REG_DROP_FLOOR:        cfg_q.drop_floor        <= cfg_wdata_i;
        fslu_pkg::REG_DELETE_AFTER_DAYS: cfg_q.delete_after_days <= cfg_wdata_i[15:0];
        fslu_pkg::REG_SAVE_FLOOR:        cfg_q.save_floor        <= cfg_wdata_i;
        fslu_pkg::REG_DELTA_FLOOR:       cfg_q.delta_floor       <= cfg_wdata_i;
        fslu_pkg::REG_KEEP_DAYS:         cfg_q.keep_days         <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  fslu_decay u_decay (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .valid_i           (accept),
    .command_i         (command_i),
    .save_mode_i       (save_mode_i),
    .show_i            (show_i),
    .click_i           (click_i),
    .delta_score_i     (delta_score_i),
    .unseen_days_i     (unseen_days_i),
    .slot_i            (slot_i),
    .show_inc_i        (show_inc_i),
    .click_inc_i       (click_inc_i),
    .push_slot_i       (push_slot_i),
    .cache_threshold_i (cache_threshold_i),
    .batch_last_i      (batch_last_i),
    .valid_o           (v2),
    .side_o            (side2),
    .op_a_o            (op_a),
    .op_b_o            (op_b)
  );

  fslu_score u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (v2),
    .side_i  (side2),
    .op_a_i  (op_a),
    .op_b_i  (op_b),
    .valid_o (v4),
    .side_o  (side4),
    .score_o (score)
  );

  fslu_decide u_decide (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .valid_i           (v4),
    .side_i            (side4),
    .score_i           (score),
    .done_o            (done_o),
    .new_show_o        (new_show_o),
    .new_click_o       (new_click_o),
    .new_delta_score_o (new_delta_score_o),
    .new_unseen_days_o (new_unseen_days_o),
    .new_slot_o        (slot_out),
    .decision_o        (decision_o),
    .result_last_o     (result_last_o)
  );

  assign new_slot_o = $signed(slot_out);

endmodule

`default_nettype wire

@@ src/fslu_checker.sv @@
// ----------------------------------------------------------------------------
// fslu_checker
// Port-level checks of item timing and selected result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module fslu_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           start_i,
  input wire logic                           busy_o,
  input wire logic [fslu_pkg::CmdW-1:0]      command_i,
  input wire logic [fslu_pkg::ModeW-1:0]     save_mode_i,
  input wire logic [fslu_pkg::DaysW-1:0]     unseen_days_i,
  input wire logic                           batch_last_i,
  input wire logic                           done_o,
  input wire logic                           decision_o,
  input wire logic [fslu_pkg::DaysW-1:0]     new_unseen_days_o,
  input wire logic                           result_last_o
);

  a_item_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("accepted item produced no result");

  a_done_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, fslu_pkg::Latency))
    else $error("result without accepted item");

  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_last_o == $past(batch_last_i, fslu_pkg::Latency))
    else $error("result_last mismatch");

  a_update_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start_i && command_i == fslu_pkg::CMD_UPDATE, fslu_pkg::Latency))
    |-> (!decision_o && new_unseen_days_o == '0))
    else $error("update result wrong");

  a_age_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start_i && command_i == fslu_pkg::CMD_AFTER_SAVE &&
                     save_mode_i == fslu_pkg::MODE_AGE &&
                     unseen_days_i != fslu_pkg::DAYS_MAX, fslu_pkg::Latency))
    |-> new_unseen_days_o ==
        fslu_pkg::DaysW'($past(unseen_days_i, fslu_pkg::Latency) + 16'd1))
    else $error("unseen days not incremented");

endmodule

bind feature_stat_lifecycle_unit fslu_checker u_fslu_checker (.*);

`default_nettype wire
